// ===== design/iorb_pkg.sv =====
package iorb_pkg;

    // Window ring and field widths
    localparam int WINDOW_DEPTH = 16;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int IDX_W        = 32;
    localparam int PAY_W        = 32;
    localparam int KIND_W       = 3;
    localparam int OP_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ORDERED   = 2'd0,
        OP_UNORDERED = 2'd1,
        OP_ERROR     = 2'd2,
        OP_FLUSH     = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_RELEASE    = 3'd0,
        KIND_LATE       = 3'd1,
        KIND_WARN       = 3'd2,
        KIND_FLUSH_DONE = 3'd3,
        KIND_OVERFLOW   = 3'd4
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic drain;
        logic flush;
        logic flush_done;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_seq;
        logic succ_valid;
        logic to_flush;
        logic flush_end;
    } t_stat;

    // Ring slot of base + off, both below the depth
    function automatic logic [WIN_AW-1:0] slot_add(input logic [WIN_AW-1:0] base,
                                                   input logic [WIN_AW-1:0] off);
        logic [WIN_AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (WIN_AW+1)'(WINDOW_DEPTH)) begin
            sum = sum - (WIN_AW+1)'(WINDOW_DEPTH);
        end
        return sum[WIN_AW-1:0];
    endfunction

endpackage

// ===== design/iorb_ctrl.sv =====
module iorb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  iorb_pkg::t_stat i_stat,
    output iorb_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import iorb_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_FLUSH  = 6'b001000,
        S_FDONE  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence the work of one item
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_stat.to_flush) begin
                    n_state = S_FLUSH;
                end else if (i_stat.in_seq && i_stat.succ_valid) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (!i_stat.succ_valid) begin
                    n_state = S_FINISH;
                end
            end
            S_FLUSH: begin
                if (i_stat.flush_end) begin
                    n_state = S_FDONE;
                end
            end
            S_FDONE:  n_state = S_IDLE;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands
    assign o_busy            = (r_state != S_IDLE);
    assign o_cmd.load        = i_start && (r_state == S_IDLE);
    assign o_cmd.exec        = (r_state == S_EXEC);
    assign o_cmd.drain       = (r_state == S_DRAIN);
    assign o_cmd.flush       = (r_state == S_FLUSH);
    assign o_cmd.flush_done  = (r_state == S_FDONE);
    assign o_cmd.finish      = (r_state == S_FINISH);

endmodule

// ===== design/iorb_dp.sv =====
module iorb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iorb_pkg::t_cmd                i_cmd,
    input  logic [iorb_pkg::OP_W-1:0]     i_operation,
    input  logic [iorb_pkg::IDX_W-1:0]    i_action_index,
    input  logic                          i_has_payload,
    input  logic [iorb_pkg::PAY_W-1:0]    i_payload_handle,
    output iorb_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [iorb_pkg::KIND_W-1:0]   o_result_kind,
    output logic                          o_error_stream,
    output logic [iorb_pkg::PAY_W-1:0]    o_released_payload,
    output logic [iorb_pkg::IDX_W-1:0]    o_released_index,
    output logic                          o_last_of_run
);
    import iorb_pkg::*;

    // Latched item
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic              r_has;
    logic [PAY_W-1:0]  r_pay;

    // Ordering state
    logic [IDX_W-1:0]        r_next,  n_next;
    logic [WIN_AW-1:0]       r_head,  n_head;
    logic [WINDOW_DEPTH-1:0] r_held_valid, n_held_valid;
    logic                    r_held_has [WINDOW_DEPTH];
    logic [PAY_W-1:0]        r_held_pay [WINDOW_DEPTH];
    logic [WIN_AW-1:0]       r_off,   n_off;

    // Pending release, kept back until it is known whether more follow
    logic              r_pend_valid, n_pend_valid;
    logic [PAY_W-1:0]  r_pend_pay,   n_pend_pay;
    logic [IDX_W-1:0]  r_pend_idx,   n_pend_idx;

    // Output beat
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_out_kind,  n_out_kind;
    logic              r_out_err,   n_out_err;
    logic [PAY_W-1:0]  r_out_pay,   n_out_pay;
    logic [IDX_W-1:0]  r_out_idx,   n_out_idx;
    logic              r_out_last,  n_out_last;

    // Ring write port
    logic              wr_en;
    logic [WIN_AW-1:0] wr_slot;

    logic [IDX_W-1:0]  idx_gap;
    logic [WIN_AW-1:0] head1;
    logic [WIN_AW-1:0] rd_slot;
    logic              rd_has;
    logic [PAY_W-1:0]  rd_pay;
    logic              any_held;

    assign idx_gap  = r_idx - r_next;
    assign head1    = slot_add(r_head, WIN_AW'(1));
    assign any_held = |r_held_valid;
    assign rd_slot  = i_cmd.flush ? slot_add(r_head, r_off) : r_head;
    assign rd_has   = r_held_has[rd_slot];
    assign rd_pay   = r_held_pay[rd_slot];
    assign wr_slot  = slot_add(r_head, idx_gap[WIN_AW-1:0]);

    assign o_stat.in_seq     = (r_op == OP_ORDERED) && (idx_gap == '0);
    assign o_stat.succ_valid = r_held_valid[head1];
    assign o_stat.to_flush   = (r_op == OP_FLUSH) && any_held;
    assign o_stat.flush_end  = (r_off == WIN_AW'(WINDOW_DEPTH - 1));

    // Decide next state and output beat
    always_comb begin
        n_next       = r_next;
        n_head       = r_head;
        n_held_valid = r_held_valid;
        n_off        = r_off;
        n_pend_valid = r_pend_valid;
        n_pend_pay   = r_pend_pay;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_err    = 1'b0;
        n_out_pay    = '0;
        n_out_idx    = '0;
        n_out_last   = 1'b1;
        wr_en        = 1'b0;

        priority if (i_cmd.exec) begin
            unique case (r_op)
                OP_FLUSH: begin
                    n_out_valid = 1'b1;
                    if (any_held) begin
                        n_out_kind = KIND_WARN;
                        n_out_err  = 1'b1;
                        n_out_last = 1'b0;
                        n_off      = WIN_AW'(1);
                    end else begin
                        n_out_kind = KIND_FLUSH_DONE;
                        n_next     = '0;
                        n_head     = '0;
                    end
                end
                OP_ERROR, OP_UNORDERED: begin
                    n_out_valid = r_has;
                    n_out_kind  = KIND_RELEASE;
                    n_out_err   = (r_op == OP_ERROR);
                    n_out_pay   = r_pay;
                end
                default: begin
                    priority if (idx_gap == '0) begin
                        n_next = r_next + IDX_W'(1);
                        n_head = head1;
                        if (r_has) begin
                            if (r_held_valid[head1]) begin
                                n_pend_valid = 1'b1;
                                n_pend_pay   = r_pay;
                                n_pend_idx   = r_idx;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_kind  = KIND_RELEASE;
                                n_out_pay   = r_pay;
                                n_out_idx   = r_idx;
                            end
                        end
                    end else if (idx_gap[IDX_W-1]) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_LATE;
                        n_out_pay   = r_pay;
                        n_out_idx   = r_idx;
                    end else if (idx_gap < IDX_W'(WINDOW_DEPTH)) begin
                        wr_en                 = 1'b1;
                        n_held_valid[wr_slot] = 1'b1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_OVERFLOW;
                        n_out_pay   = r_pay;
                        n_out_idx   = r_idx;
                    end
                end
            endcase
        end else if (i_cmd.drain) begin
            // Free the entry at the head, pend its payload, then advance
            n_held_valid[r_head] = 1'b0;
            n_next = r_next + IDX_W'(1);
            n_head = head1;
            if (rd_has) begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_RELEASE;
                    n_out_pay   = r_pend_pay;
                    n_out_idx   = r_pend_idx;
                    n_out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_pay   = rd_pay;
                n_pend_idx   = r_next;
            end
        end else if (i_cmd.finish) begin
            n_out_valid  = r_pend_valid;
            n_out_kind   = KIND_RELEASE;
            n_out_pay    = r_pend_pay;
            n_out_idx    = r_pend_idx;
            n_pend_valid = 1'b0;
        end else if (i_cmd.flush) begin
            // Walk the window, skip gaps
            n_off = r_off + WIN_AW'(1);
            if (r_held_valid[rd_slot] && rd_has) begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_RELEASE;
                n_out_pay   = rd_pay;
                n_out_idx   = r_next + IDX_W'(r_off);
                n_out_last  = 1'b0;
            end
        end else if (i_cmd.flush_done) begin
            n_out_valid  = 1'b1;
            n_out_kind   = KIND_FLUSH_DONE;
            n_held_valid = '0;
            n_next       = '0;
            n_head       = '0;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next       <= '0;
            r_head       <= '0;
            r_held_valid <= '0;
            r_off        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_next       <= n_next;
            r_head       <= n_head;
            r_held_valid <= n_held_valid;
            r_off        <= n_off;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_idx <= i_action_index;
            r_has <= i_has_payload;
            r_pay <= i_has_payload ? i_payload_handle : '0;
        end
        if (wr_en) begin
            r_held_has[wr_slot] <= r_has;
            r_held_pay[wr_slot] <= r_pay;
        end
        r_pend_pay <= n_pend_pay;
        r_pend_idx <= n_pend_idx;
        r_out_kind <= n_out_kind;
        r_out_err  <= n_out_err;
        r_out_pay  <= n_out_pay;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_out_kind;
    assign o_error_stream     = r_out_err;
    assign o_released_payload = r_out_pay;
    assign o_released_index   = r_out_idx;
    assign o_last_of_run      = r_out_last;

endmodule

// ===== design/in_order_release_buffer.sv =====
// In-order release buffer.
// Input: present a completion record on i_operation, i_action_index,
// i_has_payload and i_payload_handle with i_start high; it is taken at the
// clock edge where i_start is high and o_busy is low.
// Output: each result beat sits on the o_ result ports for exactly one cycle
// with o_valid high; o_last_of_run marks the final beat caused by a record.
// The receiver cannot stall, so results are never held back or dropped.
// Result beats are registered: the record is latched at the accepting edge
// and a beat decided while it executes is held in the output registers.
// No new record is taken while o_busy is high. An in-sequence record that
// frees held successors drains them: the drain walks the window ring one
// entry per cycle, and the final beat leaves from the finish state. A flush
// with entries held scans window offsets 1 to WINDOW_DEPTH - 1, then flush
// done follows.
// Reset (synchronous, active low) clears the expected index to zero, the
// held-valid bits and all pending beats; held payloads need no clearing.
module in_order_release_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [iorb_pkg::OP_W-1:0]     i_operation,
    input  logic [iorb_pkg::IDX_W-1:0]    i_action_index,
    input  logic                          i_has_payload,
    input  logic [iorb_pkg::PAY_W-1:0]    i_payload_handle,
    output logic                          o_valid,
    output logic [iorb_pkg::KIND_W-1:0]   o_result_kind,
    output logic                          o_error_stream,
    output logic [iorb_pkg::PAY_W-1:0]    o_released_payload,
    output logic [iorb_pkg::IDX_W-1:0]    o_released_index,
    output logic                          o_last_of_run
);
    import iorb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    iorb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Window ring and result path
    iorb_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_operation        (i_operation),
        .i_action_index     (i_action_index),
        .i_has_payload      (i_has_payload),
        .i_payload_handle   (i_payload_handle),
        .o_stat             (stat),
        .o_valid            (o_valid),
        .o_result_kind      (o_result_kind),
        .o_error_stream     (o_error_stream),
        .o_released_payload (o_released_payload),
        .o_released_index   (o_released_index),
        .o_last_of_run      (o_last_of_run)
    );

endmodule
